FILE: rtl/tgr_pkg.sv
// tgr_pkg: shared types, register codes and constants of the temperature filter
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

   // field and state widths
   localparam int TEMP_W   = 16;
   localparam int STEP_W   = 15;
   localparam int ALPHA_W  = 17;
   localparam int FRAC_SHIFT = 12;
   localparam int STATE_W  = TEMP_W + FRAC_SHIFT;
   localparam int DIFF_W   = STATE_W + 1;
   localparam int PROD_W   = DIFF_W + ALPHA_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // weight of one in Q1.16
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
   // half an lsb for the Q.32 to Q.16 rounding
   localparam logic signed [PROD_W-1:0] PROD_HALF = 47'sd32768;
   // half an lsb for the Q11.16 to Q11.4 rounding
   localparam logic signed [DIFF_W-1:0] OUT_HALF = 29'sd2048;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEMP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 2'd3;

   // register reset values
   localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = -16'sd640;
   localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd2400;
   localparam logic [STEP_W-1:0]        MAX_STEP_RST = 15'd160;
   localparam logic [ALPHA_W-1:0]       ALPHA_RST    = 17'd6554;

   typedef struct packed {
      logic signed [TEMP_W-1:0] sample;
      logic                     conv_ok;
   } req_word_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] filtered_temp;
      logic                     error;
      logic                     seeded;
   } rsp_word_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] min_temp;
      logic signed [TEMP_W-1:0] max_temp;
      logic [STEP_W-1:0]        max_step;
      logic [ALPHA_W-1:0]       smoothing_alpha;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/tgr_stream_if.sv
// tgr_stream_if: valid/ready channel carrying one word
`timescale 1ns / 1ps
`default_nettype none

interface tgr_stream_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

FILE: rtl/temp_glitch_reject_ema_filter.sv
// temp_glitch_reject_ema_filter: top level of the temperature glitch-reject filter
//
// Usage:
//   req_chan carries one word per sample: a signed Q11.4 temperature and a
//   conversion-ok flag. rsp_chan returns exactly one word per sample: the
//   filtered temperature rounded to Q11.4, an error flag and the seeded flag.
//   Both channels transfer a word when valid and ready are high at a clock edge.
//   csr_we/csr_index/csr_wdata write the range bounds, step limit and weight;
//   write them only while no sample is in flight.
// Pipeline and throughput:
//   a sample is registered in the input register, then checked and folded into
//   the average combinationally; its result is registered in the result register
//   and offered on rsp_chan. One sample is taken every cycle while rsp_chan takes
//   results, set by the single multiply-accumulate between the input and result registers.
// Reset:
//   synchronous; clears the filter to zero and unseeded, loads the register
//   defaults (-40 C, 150 C, 10 C step, weight 0.1) and empties both stages.
// Stall:
//   while the result is not taken the result register holds; the input register
//   takes one more word, then req_chan.ready drops until rsp_chan moves.
`timescale 1ns / 1ps
`default_nettype none

module temp_glitch_reject_ema_filter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tgr_stream_if.sink                          req_chan,
   tgr_stream_if.source                        rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [tgr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tgr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tgr_pkg::*;

   cfg_type      cfg;
   logic         advance;
   logic         in_valid;
   req_word_type in_word;
   rsp_word_type out_word;

   // configuration registers
   tgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   tgr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_word  (req_chan.word),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_word   (in_word)
   );

   // checks, average update and result register
   tgr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid),
      .in_word   (in_word),
      .advance   (advance),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_word  (out_word)
   );

   assign rsp_chan.word = out_word;

endmodule

`default_nettype wire

FILE: rtl/tgr_csr.sv
// tgr_csr: configuration registers of the temperature filter
`timescale 1ns / 1ps
`default_nettype none

module tgr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [tgr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tgr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output tgr_pkg::cfg_type                       cfg
);
   import tgr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_TEMP: cfg_in.min_temp        = signed'(csr_wdata[TEMP_W-1:0]);
            CSR_MAX_TEMP: cfg_in.max_temp        = signed'(csr_wdata[TEMP_W-1:0]);
            CSR_MAX_STEP: cfg_in.max_step        = csr_wdata[STEP_W-1:0];
            CSR_ALPHA:    cfg_in.smoothing_alpha = csr_wdata[ALPHA_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_temp        <= MIN_TEMP_RST;
         cfg_ff.max_temp        <= MAX_TEMP_RST;
         cfg_ff.max_step        <= MAX_STEP_RST;
         cfg_ff.smoothing_alpha <= ALPHA_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // a write to the step limit leaves the range bounds alone
   a_step_write_local: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_MAX_STEP |=> $stable(cfg_ff.min_temp) && $stable(cfg_ff.max_temp))
      else $error("step limit write disturbed range bounds");

   // without a write every register holds
   a_hold_no_write: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> $stable(cfg_ff))
      else $error("configuration changed without a write");

   // a write to the weight lands in the weight register
   a_alpha_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_ALPHA |=> cfg_ff.smoothing_alpha == $past(csr_wdata))
      else $error("weight write lost");

endmodule

`default_nettype wire

FILE: rtl/tgr_in_stage.sv
// tgr_in_stage: input register in front of the filter datapath
`timescale 1ns / 1ps
`default_nettype none

module tgr_in_stage (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire tgr_pkg::req_word_type req_word,
   input  wire logic           advance,
   output logic                in_valid,
   output tgr_pkg::req_word_type in_word
);
   import tgr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;

   // the register is free when empty or when its word moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

   // a held word is not dropped
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !advance |=> valid_ff && $stable(word_ff))
      else $error("pending input word lost");

   // the datapath only takes a word that is there
   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |-> valid_ff)
      else $error("datapath advanced on an empty input register");

   // an accepted word is present in the next cycle
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff)
      else $error("accepted word not captured");

endmodule

`default_nettype wire

FILE: rtl/tgr_core.sv
// tgr_core: range and slew checks, moving average update and result register
`timescale 1ns / 1ps
`default_nettype none

module tgr_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tgr_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   input  wire tgr_pkg::req_word_type in_word,
   output logic                  advance,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tgr_pkg::rsp_word_type rsp_word
);
   import tgr_pkg::*;

   logic signed [STATE_W-1:0] fv_ff;
   logic signed [STATE_W-1:0] fv_in;
   logic                      seeded_ff;
   logic                      seeded_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   rsp_word_type              out_word_ff;
   rsp_word_type              out_word_in;

   logic signed [STATE_W-1:0] s16;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  lim;
   logic                      range_bad;
   logic                      slew_bad;
   logic                      take;
   logic [ALPHA_W-1:0]        alpha_sat;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_rnd;
   logic signed [STATE_W-1:0] fv_upd;
   logic signed [DIFF_W-1:0]  out_rnd;

   // result register free when empty or being taken
   assign advance = in_valid && (!out_valid_ff || rsp_ready);

   // range and slew checks
   assign s16       = {in_word.sample, {FRAC_SHIFT{1'b0}}};
   assign diff      = DIFF_W'(s16) - DIFF_W'(fv_ff);
   assign lim       = signed'({2'b00, cfg.max_step, {FRAC_SHIFT{1'b0}}});
   assign range_bad = !in_word.conv_ok || (in_word.sample < cfg.min_temp)
                      || (in_word.sample > cfg.max_temp);
   assign slew_bad  = seeded_ff && ((diff > lim) || (diff < -lim));
   assign take      = !range_bad && !slew_bad;

   // moving average step, rounded to nearest with ties up
   assign alpha_sat = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
   assign prod      = PROD_W'(signed'({1'b0, alpha_sat})) * PROD_W'(diff);
   assign prod_rnd  = prod + PROD_HALF;
   assign fv_upd    = fv_ff + prod_rnd[STATE_W+15:16];

   // next state
   always_comb begin
      fv_in     = fv_ff;
      seeded_in = seeded_ff;
      if (advance && take) begin
         fv_in     = seeded_ff ? fv_upd : s16;
         seeded_in = 1'b1;
      end
   end

   // output rounding to Q11.4 with saturation
   assign out_rnd = DIFF_W'(fv_in) + OUT_HALF;

   always_comb begin
      out_word_in.error  = !take;
      out_word_in.seeded = seeded_in;
      if (out_rnd[DIFF_W-1] != out_rnd[DIFF_W-2]) begin
         out_word_in.filtered_temp = out_rnd[DIFF_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}}
                                                       : {1'b0, {(TEMP_W-1){1'b1}}};
      end else begin
         out_word_in.filtered_temp = out_rnd[DIFF_W-2:FRAC_SHIFT];
      end
   end

   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff        <= '0;
         seeded_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fv_ff        <= fv_in;
         seeded_ff    <= seeded_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // the filter stays seeded
   a_seed_sticky: assert property (@(posedge clock) disable iff (reset)
      seeded_ff |=> seeded_ff)
      else $error("filter lost its seed");

   // an unseeded filter holds zero
   a_unseeded_zero: assert property (@(posedge clock) disable iff (reset)
      !seeded_ff |-> fv_ff == '0)
      else $error("unseeded filter state not zero");

   // a rejected sample leaves the state alone
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      advance && !take |=> $stable(fv_ff) && $stable(seeded_ff))
      else $error("rejected sample changed the filter");

   // a clean result always comes from a seeded filter
   a_ok_seeded: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_word_ff.error |-> out_word_ff.seeded)
      else $error("accepted sample reported an unseeded filter");

endmodule

`default_nettype wire
